FILE: hw/rtl/hjog_pkg.sv
// Shared types, widths and register codes for the Halton jitter offset generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hjog_pkg;

    // fractional precision of the radical inverses
    localparam int FRAC_BITS_DEF = 24;
    localparam int FRAC_MAX      = 32;

    // field widths
    localparam int SIZE_W  = 16;
    localparam int FRAME_W = 32;
    localparam int COUNT_W = 35;
    localparam int PIX_W   = 24;
    localparam int NDC_W   = 26;

    // stream data widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 168;

    // shared divider: dividend/quotient, divisor/remainder, step counter
    localparam int DIV_AW = 36;
    localparam int DIV_DW = 35;
    localparam int DIV_SW = 6;

    // digit splitter: value width, bits per cycle, padded width
    localparam int DIG_NW     = 33;
    localparam int DIG_CHUNK  = 8;
    localparam int DIG_CHUNKS = (DIG_NW + DIG_CHUNK - 1) / DIG_CHUNK;
    localparam int DIG_PW     = DIG_CHUNKS * DIG_CHUNK;

    // configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    typedef enum logic [1:0] {
        REG_RENDER_W  = 2'd0,
        REG_RENDER_H  = 2'd1,
        REG_DISPLAY_W = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0] render_width;
        logic [SIZE_W-1:0] render_height;
        logic [SIZE_W-1:0] display_width;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] rem_init;
        logic [DIV_AW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
        logic [DIV_SW-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_AW-1:0] quot;
        logic [DIV_DW-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic              start;
        logic              base3;
        logic [DIG_NW-1:0] n;
    } t_dig_req;

    typedef struct packed {
        logic              done;
        logic [DIG_NW-1:0] quot;
        logic [1:0]        digit;
    } t_dig_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/halton_jitter_offset_generator.sv
// Top level: sequencer around the shared divider, digit splitter and register file.
// Depends on hjog_pkg, hjog_cfg, hjog_div, hjog_digit.
//
//   channel   direction  handshake                 payload
//   s stream  in         i_s_tvalid / o_s_tready   i_s_tdata[31:0] frame_index
//   m stream  out        o_m_tvalid / i_m_tready   o_m_tdata, fields listed at the port
//   apb       in/out     psel, penable, pready     paddr, pwdata, prdata
//
// When render or display width is zero the phase count division is skipped and the
// phase count is 1. Digits of phase_index+1 are taken in bases 2 and 3 (at most 33
// and 21 digits). The bit-serial divider runs 36 steps for the phase count, the
// modulo and each NDC offset, FRAC_BITS steps per radical inverse; the base-3 digit
// splitter takes eight bits per step. Synchronous active-low reset; configuration
// registers come up as 1, the sequencer idle and the output invalid; work registers
// have no reset. The input is taken only when the sequencer is idle; a finished
// result waits in the output register while the next input is taken and worked on.
`default_nettype none

module halton_jitter_offset_generator
    import hjog_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // apb configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [CFG_AW-1:0]    paddr,
    input  wire logic [CFG_DW-1:0]    pwdata,
    output      logic [CFG_DW-1:0]    prdata,
    output      logic                 pready,
    // input stream
    input  wire logic                 i_s_tvalid,
    output      logic                 o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // [31:0] frame_index
    // output stream
    output      logic                 o_m_tvalid,
    input  wire logic                 i_m_tready,
    output      logic [M_TDATA_W-1:0] o_m_tdata   // [34:0] phase_count, [66:35] phase_index,
                                                  // [90:67] pixel_offset_x,
                                                  // [114:91] pixel_offset_y,
                                                  // [140:115] ndc_offset_x,
                                                  // [166:141] ndc_offset_y, [167] zero
);

    localparam int PSH = (FRAC_BITS >= PIX_W) ? FRAC_BITS - PIX_W : 0;
    localparam int NSH = (FRAC_BITS < PIX_W) ? PIX_W - FRAC_BITS : 0;
    localparam logic [DIV_AW-1:0] HALF_FB  = {{(DIV_AW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic [PIX_W-1:0]  PIX_HALF = {1'b1, {(PIX_W-1){1'b0}}};

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_MUL_D    = 9'b000000010,
        S_MUL_R    = 9'b000000100,
        S_DIV_GO   = 9'b000001000,
        S_DIV_WAIT = 9'b000010000,
        S_DIG_INIT = 9'b000100000,
        S_DIG_GO   = 9'b001000000,
        S_DIG_WAIT = 9'b010000000,
        S_OUT      = 9'b100000000
    } t_state;

    typedef enum logic [2:0] {
        JOB_COUNT = 3'd0,
        JOB_MOD   = 3'd1,
        JOB_FRAC  = 3'd2,
        JOB_NDC_X = 3'd3,
        JOB_NDC_Y = 3'd4
    } t_job;

    t_cfg     w_cfg;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    t_dig_req w_dig_req;
    t_dig_rsp w_dig_rsp;

    // control state
    t_state r_state, n_state;
    t_job   r_job, n_job;
    logic   r_base3, n_base3;
    logic   r_ovalid;

    // work registers
    logic [FRAME_W-1:0]  r_frame;
    logic [2*SIZE_W-1:0] r_dsq;
    logic [2*SIZE_W-1:0] r_rsq;
    logic [COUNT_W-1:0]  r_count;
    logic [FRAME_W-1:0]  r_idx;
    logic [DIG_NW-1:0]   r_n;
    logic [DIV_DW-1:0]   r_m, n_m;
    logic [DIV_DW-1:0]   r_den, n_den;
    logic [FRAC_MAX-1:0] r_hx;
    logic [FRAC_MAX-1:0] r_hy;
    logic                r_neg;
    logic [NDC_W-1:0]    r_ndc_x;
    logic [NDC_W-1:0]    r_ndc_y;

    // output register
    logic [COUNT_W-1:0]  r_o_count;
    logic [FRAME_W-1:0]  r_o_idx;
    logic [PIX_W-1:0]    r_o_pix_x;
    logic [PIX_W-1:0]    r_o_pix_y;
    logic [NDC_W-1:0]    r_o_ndc_x;
    logic [NDC_W-1:0]    r_o_ndc_y;

    logic                w_s_xfer;
    logic                w_out_load;
    logic [SIZE_W-1:0]   w_mul_a;
    logic [2*SIZE_W-1:0] w_prod;
    logic                w_size_zero;
    logic [DIV_AW-1:0]   w_num;
    logic [FRAC_MAX-1:0] w_h;
    logic [DIV_AW-1:0]   w_hv;
    logic                w_pneg;
    logic [DIV_AW-1:0]   w_pmag;
    logic [DIV_AW-1:0]   w_nmag;
    logic [SIZE_W-1:0]   w_size;
    logic [SIZE_W-1:0]   w_size_nz;
    logic [DIV_DW-1:0]   w_nden;
    logic                w_nneg;
    logic [NDC_W-1:0]    w_q;
    logic [NDC_W-1:0]    w_ndc;
    logic [DIV_DW-1:0]   w_digit;
    logic [PIX_W-1:0]    w_pix_x;
    logic [PIX_W-1:0]    w_pix_y;

    hjog_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hjog_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    hjog_digit u_digit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dig_req),
        .o_rsp   (w_dig_rsp)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_xfer   = i_s_tvalid && o_s_tready;
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || i_m_tready);

    // one squarer shared by display and render width
    assign w_mul_a     = (r_state == S_MUL_D) ? w_cfg.display_width : w_cfg.render_width;
    assign w_prod      = {{SIZE_W{1'b0}}, w_mul_a} * {{SIZE_W{1'b0}}, w_mul_a};
    assign w_size_zero = (w_cfg.render_width == '0) || (w_cfg.display_width == '0);

    // ceiling division: (8*D^2 + R^2 - 1) / R^2
    assign w_num = {1'b0, r_dsq, 3'b000} + DIV_AW'(r_rsq) - DIV_AW'(1);

    // ndc operands: magnitude of 2*(h - 1/2) over the size, sign applied afterwards
    assign w_h       = (r_job == JOB_NDC_X) ? r_hx : r_hy;
    assign w_hv      = DIV_AW'(w_h);
    assign w_pneg    = w_hv < HALF_FB;
    assign w_pmag    = w_pneg ? (HALF_FB - w_hv) : (w_hv - HALF_FB);
    assign w_nmag    = (w_pmag << 1) << NSH;
    assign w_size    = (r_job == JOB_NDC_X) ? w_cfg.render_width : w_cfg.render_height;
    assign w_size_nz = (w_size == '0) ? SIZE_W'(1) : w_size;
    assign w_nden    = DIV_DW'(w_size_nz) << PSH;
    assign w_nneg    = (r_job == JOB_NDC_X) ? w_pneg : !w_pneg;

    assign w_q   = w_div_rsp.quot[NDC_W-1:0];
    assign w_ndc = r_neg ? (NDC_W'(0) - w_q) : w_q;

    // divider job select
    always_comb begin
        w_div_req          = '0;
        w_div_req.start    = (r_state == S_DIV_GO);
        w_div_req.steps    = DIV_SW'(DIV_AW);
        unique case (r_job)
            JOB_COUNT: begin
                w_div_req.dividend = w_num;
                w_div_req.divisor  = DIV_DW'(r_rsq);
            end
            JOB_MOD: begin
                w_div_req.dividend = DIV_AW'(r_frame);
                w_div_req.divisor  = r_count;
            end
            JOB_FRAC: begin
                w_div_req.rem_init = r_m;
                w_div_req.divisor  = r_den;
                w_div_req.steps    = DIV_SW'(FRAC_BITS);
            end
            JOB_NDC_X, JOB_NDC_Y: begin
                w_div_req.dividend = w_nmag;
                w_div_req.divisor  = w_nden;
            end
            default: ;
        endcase
    end

    // digit split of the remaining value
    assign w_dig_req.start = (r_state == S_DIG_GO) && (r_n != '0);
    assign w_dig_req.base3 = r_base3;
    assign w_dig_req.n     = r_n;

    // reversed-digit numerator and base power
    assign w_digit = DIV_DW'(w_dig_rsp.digit);
    always_comb begin
        if (r_base3) begin
            n_m   = (r_m << 1) + r_m + w_digit;
            n_den = (r_den << 1) + r_den;
        end else begin
            n_m   = (r_m << 1) + w_digit;
            n_den = r_den << 1;
        end
    end

    // pixel offsets: rescale to 24 fraction bits, subtracting one half flips the top bit
    assign w_pix_x = PIX_W'((r_hx >> PSH) << NSH) ^ PIX_HALF;
    assign w_pix_y = PIX_W'((r_hy >> PSH) << NSH) ^ PIX_HALF;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_base3 = r_base3;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_xfer) n_state = S_MUL_D;
            end
            S_MUL_D: n_state = S_MUL_R;
            S_MUL_R: begin
                n_state = S_DIV_GO;
                n_job   = w_size_zero ? JOB_MOD : JOB_COUNT;
                n_base3 = 1'b0;
            end
            S_DIV_GO: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    unique case (r_job)
                        JOB_COUNT: begin
                            n_job   = JOB_MOD;
                            n_state = S_DIV_GO;
                        end
                        JOB_MOD: n_state = S_DIG_INIT;
                        JOB_FRAC: begin
                            if (r_base3) begin
                                n_job   = JOB_NDC_X;
                                n_state = S_DIV_GO;
                            end else begin
                                n_base3 = 1'b1;
                                n_state = S_DIG_INIT;
                            end
                        end
                        JOB_NDC_X: begin
                            n_job   = JOB_NDC_Y;
                            n_state = S_DIV_GO;
                        end
                        JOB_NDC_Y: n_state = S_OUT;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_DIG_INIT: n_state = S_DIG_GO;
            S_DIG_GO: begin
                if (r_n == '0) begin
                    n_job   = JOB_FRAC;
                    n_state = S_DIV_GO;
                end else begin
                    n_state = S_DIG_WAIT;
                end
            end
            S_DIG_WAIT: begin
                if (w_dig_rsp.done) n_state = S_DIG_GO;
            end
            S_OUT: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_job    <= JOB_COUNT;
            r_base3  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_base3 <= n_base3;
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_s_xfer) r_frame <= i_s_tdata[FRAME_W-1:0];
            end
            S_MUL_D: r_dsq <= w_prod;
            S_MUL_R: begin
                r_rsq <= w_prod;
                if (w_size_zero) r_count <= COUNT_W'(1);
            end
            S_DIV_GO: begin
                r_neg <= w_nneg;
            end
            S_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    unique case (r_job)
                        JOB_COUNT: r_count <= w_div_rsp.quot[COUNT_W-1:0];
                        JOB_MOD:   r_idx   <= w_div_rsp.rem[FRAME_W-1:0];
                        JOB_FRAC: begin
                            if (r_base3) r_hy <= w_div_rsp.quot[FRAC_MAX-1:0];
                            else         r_hx <= w_div_rsp.quot[FRAC_MAX-1:0];
                        end
                        JOB_NDC_X: r_ndc_x <= w_ndc;
                        JOB_NDC_Y: r_ndc_y <= w_ndc;
                        default: ;
                    endcase
                end
            end
            S_DIG_INIT: begin
                r_n   <= {1'b0, r_idx} + DIG_NW'(1);
                r_m   <= '0;
                r_den <= DIV_DW'(1);
            end
            S_DIG_GO: ;
            S_DIG_WAIT: begin
                if (w_dig_rsp.done) begin
                    r_n   <= w_dig_rsp.quot;
                    r_m   <= n_m;
                    r_den <= n_den;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    r_o_count <= r_count;
                    r_o_idx   <= r_idx;
                    r_o_pix_x <= w_pix_x;
                    r_o_pix_y <= w_pix_y;
                    r_o_ndc_x <= r_ndc_x;
                    r_o_ndc_y <= r_ndc_y;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_o_ndc_y, r_o_ndc_x, r_o_pix_y, r_o_pix_x, r_o_idx, r_o_count};

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_MUL_D))
        else $error("accepted transfer did not start the sequencer");

    a_index_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> ({{(COUNT_W-FRAME_W){1'b0}}, r_o_idx} < r_o_count))
        else $error("phase index not below phase count");

    a_ndc_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_pix_x[PIX_W-1]) |-> (r_o_ndc_x[NDC_W-1] || (r_o_ndc_x == '0)))
        else $error("ndc x sign disagrees with pixel x offset");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT))
        else $error("output register loaded outside the output state");

endmodule

`default_nettype wire

FILE: hw/rtl/hjog_cfg.sv
// APB register file: render width, render height, display width.
// Depends on hjog_pkg.
`default_nettype none

module hjog_cfg
    import hjog_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output      logic [CFG_DW-1:0] prdata,
    output      logic              pready,
    output      t_cfg              o_cfg
);

    logic [SIZE_W-1:0] r_render_w;
    logic [SIZE_W-1:0] r_render_h;
    logic [SIZE_W-1:0] r_display_w;
    t_reg_idx          w_idx;
    logic              w_wr;

    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_render_w  <= SIZE_W'(1);
            r_render_h  <= SIZE_W'(1);
            r_display_w <= SIZE_W'(1);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RENDER_W:  r_render_w  <= pwdata[SIZE_W-1:0];
                REG_RENDER_H:  r_render_h  <= pwdata[SIZE_W-1:0];
                REG_DISPLAY_W: r_display_w <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (w_idx)
            REG_RENDER_W:  prdata = CFG_DW'(r_render_w);
            REG_RENDER_H:  prdata = CFG_DW'(r_render_h);
            REG_DISPLAY_W: prdata = CFG_DW'(r_display_w);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.render_width  = r_render_w;
    assign o_cfg.render_height = r_render_h;
    assign o_cfg.display_width = r_display_w;

endmodule

`default_nettype wire

FILE: hw/rtl/hjog_div.sv
// Shared restoring divider, one quotient bit per cycle, with a loadable start remainder.
// Depends on hjog_pkg.
`default_nettype none

module hjog_div
    import hjog_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output      t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_SW-1:0] r_cnt;
    logic [DIV_AW-1:0] r_aq;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;

    logic [DIV_DW:0]   w_trial;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;
    logic [DIV_DW-1:0] n_rem;

    // one trial subtract per cycle
    assign w_trial = {r_rem, r_aq[DIV_AW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign n_rem   = w_ge ? w_diff[DIV_DW-1:0] : w_trial[DIV_DW-1:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_SW'(1);
                if (r_cnt == DIV_SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits enter the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_aq  <= i_req.dividend;
            r_rem <= i_req.rem_init;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_aq  <= {r_aq[DIV_AW-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_aq;
    assign o_rsp.rem  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dvs))
        else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

FILE: hw/rtl/hjog_digit.sv
// Digit splitter: n / b and n % b; base 2 as a shift registered at the request, base 3 eight bits a cycle.
// Depends on hjog_pkg.
`default_nettype none

module hjog_digit
    import hjog_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dig_req i_req,
    output      t_dig_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIG_CHUNKS + 1);
    localparam logic [2:0] THREE = 3'd3;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIG_PW-1:0]    r_sh;
    logic [1:0]           r_rem;

    logic [DIG_CHUNK-1:0] w_qb;
    logic [1:0]           w_rem;
    logic [2:0]           w_t;

    // eight long-division steps by three on a two-bit remainder
    always_comb begin
        w_rem = r_rem;
        w_qb  = '0;
        w_t   = '0;
        for (int i = 0; i < DIG_CHUNK; i++) begin
            w_t = {w_rem, r_sh[DIG_PW-1-i]};
            if (w_t >= THREE) begin
                w_qb[DIG_CHUNK-1-i] = 1'b1;
                w_rem = 2'(w_t - THREE);
            end else begin
                w_rem = w_t[1:0];
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= i_req.base3;
                r_done <= !i_req.base3;
                r_cnt  <= CNT_W'(DIG_CHUNKS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // value shifts out the top, quotient bits fill in from the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            if (i_req.base3) begin
                r_sh  <= DIG_PW'(i_req.n);
                r_rem <= 2'b00;
            end else begin
                r_sh  <= DIG_PW'(i_req.n >> 1);
                r_rem <= {1'b0, i_req.n[0]};
            end
        end else if (r_busy) begin
            r_sh  <= {r_sh[DIG_PW-DIG_CHUNK-1:0], w_qb};
            r_rem <= w_rem;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.quot  = r_sh[DIG_NW-1:0];
    assign o_rsp.digit = r_rem;

endmodule

`default_nettype wire
